FILE: design/spq_pkg.sv
// Shared types, codes and sizes for the sorted priority queue.
package spq_pkg;

  localparam int unsigned TAG_BITS        = 16;
  localparam int unsigned PRIO_BITS       = 8;
  localparam int unsigned OCC_BITS        = 8;
  localparam int unsigned DEF_QUEUE_DEPTH = 128;

  typedef enum logic [0:0] {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ_RD,
    S_SCAN,
    S_PLACE_HEAD
  } state_e;

  typedef struct packed {
    action_e               action;
    logic [TAG_BITS-1:0]   job_tag;
    logic [PRIO_BITS-1:0]  job_priority;
  } req_t;

  typedef struct packed {
    status_e               status;
    logic [TAG_BITS-1:0]   out_tag;
    logic [PRIO_BITS-1:0]  out_priority;
    logic [OCC_BITS-1:0]   occupancy;
  } res_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]   tag;
    logic [PRIO_BITS-1:0]  prio;
  } entry_t;

endpackage

FILE: design/spq_mem.sv
// Entry storage: one write port and one registered read port.
module spq_mem #(
  parameter int unsigned QueueDepth = spq_pkg::DEF_QUEUE_DEPTH,
  localparam int unsigned AddrW     = $clog2(QueueDepth)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  spq_pkg::entry_t     wdata_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_i,
  output spq_pkg::entry_t     rdata_o
);

  spq_pkg::entry_t mem_q [QueueDepth];
  spq_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/spq_ctrl.sv
// Sequencer: insertion walk, head pop, count and result register.
module spq_ctrl #(
  parameter int unsigned QueueDepth = spq_pkg::DEF_QUEUE_DEPTH,
  localparam int unsigned AddrW     = $clog2(QueueDepth),
  localparam int unsigned CntW      = $clog2(QueueDepth + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  spq_pkg::req_t       req_i,
  output logic                busy_o,
  output logic                done_o,
  output spq_pkg::res_t       res_o,
  output logic                we_o,
  output logic [AddrW-1:0]    waddr_o,
  output spq_pkg::entry_t     wdata_o,
  output logic                re_o,
  output logic [AddrW-1:0]    raddr_o,
  input  spq_pkg::entry_t     rdata_i
);

  localparam int unsigned OccW = spq_pkg::OCC_BITS;
  localparam int unsigned TagW = spq_pkg::TAG_BITS;
  localparam int unsigned PriW = spq_pkg::PRIO_BITS;

  spq_pkg::state_e  state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0] j_q, j_d;
  spq_pkg::entry_t  new_q, new_d;
  spq_pkg::res_t    res_q, res_d;
  logic             done_q, done_d;
  logic             shift;

  // Storage is kept reversed: slot 0 is the tail, slot cnt-1 the head.
  assign shift = rdata_i.prio > new_q.prio;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q   <= j_d;
    new_q <= new_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    j_d     = j_q;
    new_d   = new_q;
    res_d   = res_q;
    done_d  = 1'b0;
    we_o    = 1'b0;
    waddr_o = j_q;
    wdata_o = new_q;
    re_o    = 1'b0;
    raddr_o = '0;

    case (state_q)
      spq_pkg::S_IDLE: begin
        if (start_i) begin
          if (req_i.action == spq_pkg::ACT_DEQ) begin
            if (cnt_q == '0) begin
              res_d  = '{spq_pkg::ST_EMPTY, '0, '0, '0};
              done_d = 1'b1;
            end else begin
              re_o    = 1'b1;
              raddr_o = AddrW'(cnt_q - CntW'(1));
              state_d = spq_pkg::S_DEQ_RD;
            end
          end else if (cnt_q == CntW'(QueueDepth)) begin
            res_d  = '{spq_pkg::ST_FULL, '0, '0, OccW'(cnt_q)};
            done_d = 1'b1;
          end else begin
            new_d = '{req_i.job_tag, req_i.job_priority};
            if (cnt_q == '0) begin
              we_o    = 1'b1;
              waddr_o = '0;
              wdata_o = '{req_i.job_tag, req_i.job_priority};
              cnt_d   = CntW'(1);
              res_d   = '{spq_pkg::ST_DONE, '0, '0, OccW'(1)};
              done_d  = 1'b1;
            end else begin
              re_o    = 1'b1;
              raddr_o = AddrW'(cnt_q - CntW'(1));
              j_d     = AddrW'(cnt_q);
              state_d = spq_pkg::S_SCAN;
            end
          end
        end
      end

      spq_pkg::S_DEQ_RD: begin
        cnt_d   = cnt_q - CntW'(1);
        res_d   = '{spq_pkg::ST_DONE, TagW'(rdata_i.tag), PriW'(rdata_i.prio),
                    OccW'(cnt_q - CntW'(1))};
        done_d  = 1'b1;
        state_d = spq_pkg::S_IDLE;
      end

      spq_pkg::S_SCAN: begin
        we_o    = 1'b1;
        waddr_o = j_q;
        if (shift) begin
          // Move the higher entry up one slot and fetch the next one down.
          wdata_o = rdata_i;
          j_d     = j_q - AddrW'(1);
          if (j_q == AddrW'(1)) begin
            state_d = spq_pkg::S_PLACE_HEAD;
          end else begin
            re_o    = 1'b1;
            raddr_o = j_q - AddrW'(2);
          end
        end else begin
          wdata_o = new_q;
          cnt_d   = cnt_q + CntW'(1);
          res_d   = '{spq_pkg::ST_DONE, '0, '0, OccW'(cnt_q + CntW'(1))};
          done_d  = 1'b1;
          state_d = spq_pkg::S_IDLE;
        end
      end

      spq_pkg::S_PLACE_HEAD: begin
        we_o    = 1'b1;
        waddr_o = '0;
        wdata_o = new_q;
        cnt_d   = cnt_q + CntW'(1);
        res_d   = '{spq_pkg::ST_DONE, '0, '0, OccW'(cnt_q + CntW'(1))};
        done_d  = 1'b1;
        state_d = spq_pkg::S_IDLE;
      end

      default: begin
        state_d = spq_pkg::S_IDLE;
      end
    endcase
  end

  assign busy_o = state_q != spq_pkg::S_IDLE;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: design/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: sequencer plus entry storage.
//
// A fixed-capacity job queue kept sorted by priority. Drive start high with a
// request beat on req_i; the beat is taken at a rising edge where busy is low.
// Every request gives exactly one result beat on res_o, marked by done_o for a
// single cycle; the receiver cannot stall it, so sample res_o whenever done_o
// is high. An enqueue that finds the queue full, a dequeue that finds it empty,
// and an enqueue into an empty queue finish at once: the result shows the next
// cycle and busy never rises. A dequeue makes one memory read of the head.
// An enqueue walks down from the head end of the storage, moving one entry
// per cycle through the single read and write port of the entry memory until
// it finds an entry with a priority no higher than the new one. Among equal
// priorities the newest job is served first. Occupancy reports the stored
// job count after the request. No clearing pass follows reset: slots are
// only read below the count.
module sorted_priority_queue_unit #(
  parameter int unsigned QueueDepth = spq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  spq_pkg::req_t  req_i,
  output logic           done_o,
  output spq_pkg::res_t  res_o
);

  localparam int unsigned AddrW = $clog2(QueueDepth);
  localparam int unsigned OccW  = spq_pkg::OCC_BITS;
  localparam logic [OccW-1:0] OccFull = OccW'(QueueDepth);

  logic             we;
  logic [AddrW-1:0] waddr;
  spq_pkg::entry_t  wdata;
  logic             re;
  logic [AddrW-1:0] raddr;
  spq_pkg::entry_t  rdata;

  // Sequencer: owns the count, the insertion walk and the result register.
  spq_ctrl #(
    .QueueDepth(QueueDepth)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (req_i),
    .busy_o  (busy),
    .done_o  (done_o),
    .res_o   (res_o),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .re_o    (re),
    .raddr_o (raddr),
    .rdata_i (rdata)
  );

  // Entry storage, tail at slot 0 and head at the top of the filled range.
  spq_mem #(
    .QueueDepth(QueueDepth)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // A full rejection always reports a full queue.
  a_full_occ : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.status == spq_pkg::ST_FULL |-> res_o.occupancy == OccFull)
    else $error("full rejection with wrong occupancy");

  // An empty dequeue carries no job and an empty count.
  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.status == spq_pkg::ST_EMPTY |->
      res_o.out_tag == '0 && res_o.out_priority == '0 && res_o.occupancy == '0)
    else $error("empty dequeue carries data");

  // Busy only rises on a taken request beat.
  a_busy_rise : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // No result beat is produced while a request is still being worked on.
  a_busy_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy && $past(busy) |-> !done_o)
    else $error("result beat during a walk");

endmodule
